>>> src/pgtd_pkg.sv
package pgtd_pkg;

  localparam int PRIME_STORE_DEPTH = 4096;
  localparam int PRIME_W = 16;
  localparam int CAND_W = 17;
  localparam int COUNT_W = 13;
  localparam int STEP_W = 4;

  localparam logic [COUNT_W-1:0] MAX_PRIMES_RST = 13'd4096;
  localparam logic [CAND_W-1:0] CAND_RST = 17'd3;
  localparam logic [CAND_W-1:0] CAND_STEP = 17'd2;
  localparam logic [PRIME_W-1:0] FIRST_PRIME = 16'd2;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_OWAIT = 4'd1;
  localparam step_t S_CHKF  = 4'd2;
  localparam step_t S_CHK1  = 4'd3;
  localparam step_t S_TRI   = 4'd4;
  localparam step_t S_LOOP  = 4'd5;
  localparam step_t S_RD    = 4'd6;
  localparam step_t S_SQ    = 4'd7;
  localparam step_t S_CMP   = 4'd8;
  localparam step_t S_WAIT  = 4'd9;
  localparam step_t S_TEST  = 4'd10;
  localparam step_t S_NEXTC = 4'd11;
  localparam step_t S_ADV   = 4'd12;
  localparam step_t S_PASS  = 4'd13;
  localparam step_t S_FIRST = 4'd14;
  localparam step_t S_FULL  = 4'd15;

  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NO_REQ   = 4'd2,
    C_OUT_BUSY = 4'd3,
    C_FULL     = 4'd4,
    C_FIRST    = 4'd5,
    C_IDX_END  = 4'd6,
    C_SQ_GT    = 4'd7,
    C_DIV_BUSY = 4'd8,
    C_REM_NZ   = 4'd9
  } cond_t;

  typedef enum logic [1:0] {
    EM_NONE  = 2'd0,
    EM_PRIME = 2'd1,
    EM_TWO   = 2'd2,
    EM_FULL  = 2'd3
  } emit_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  idx_clr;
    logic  idx_inc;
    logic  p_ld;
    logic  sq_ld;
    logic  div_go;
    logic  cand_inc;
    logic  tbl_wr;
    logic  cnt_inc;
    emit_t emit;
  } uword_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } rem_stat_t;

  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    w = '0;
    unique case (pc)
      S_IDLE: begin
        w.cond = C_NO_REQ;
        w.target = S_IDLE;
      end
      S_OWAIT: begin
        w.cond = C_OUT_BUSY;
        w.target = S_OWAIT;
      end
      S_CHKF: begin
        w.cond = C_FULL;
        w.target = S_FULL;
      end
      S_CHK1: begin
        w.cond = C_FIRST;
        w.target = S_FIRST;
      end
      S_TRI: begin
        w.idx_clr = 1'b1;
      end
      S_LOOP: begin
        w.cond = C_IDX_END;
        w.target = S_PASS;
      end
      S_RD: begin
        w.p_ld = 1'b1;
      end
      S_SQ: begin
        w.sq_ld = 1'b1;
        w.div_go = 1'b1;
      end
      S_CMP: begin
        w.cond = C_SQ_GT;
        w.target = S_PASS;
      end
      S_WAIT: begin
        w.cond = C_DIV_BUSY;
        w.target = S_WAIT;
      end
      S_TEST: begin
        w.cond = C_REM_NZ;
        w.target = S_ADV;
      end
      S_NEXTC: begin
        w.cand_inc = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_TRI;
      end
      S_ADV: begin
        w.idx_inc = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_LOOP;
      end
      S_PASS: begin
        w.tbl_wr = 1'b1;
        w.emit = EM_PRIME;
        w.cand_inc = 1'b1;
        w.cnt_inc = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_FIRST: begin
        w.tbl_wr = 1'b1;
        w.emit = EM_TWO;
        w.cnt_inc = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_FULL: begin
        w.emit = EM_FULL;
        w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

>>> src/pgtd_rem.sv
module pgtd_rem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pgtd_pkg::CAND_W-1:0]  dividend,
  input  logic [pgtd_pkg::PRIME_W-1:0] divisor,
  output pgtd_pkg::rem_stat_t          stat
);

  localparam int CW = $clog2(pgtd_pkg::CAND_W + 1);

  logic                         busy;
  logic [CW-1:0]                cnt;
  logic [pgtd_pkg::CAND_W-1:0]  shreg;
  logic [pgtd_pkg::PRIME_W-1:0] rem;
  logic [pgtd_pkg::PRIME_W-1:0] dvs;

  logic [pgtd_pkg::PRIME_W:0]   trial;
  logic [pgtd_pkg::PRIME_W:0]   diff;
  logic                         ge;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem, shreg[pgtd_pkg::CAND_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(pgtd_pkg::CAND_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= ge ? diff[pgtd_pkg::PRIME_W-1:0] : trial[pgtd_pkg::PRIME_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.zero = (rem == '0);

endmodule

>>> src/prime_generator_trial_division.sv
// Sequence: an accepted request waits for any held result to be taken, then answers
// store-full, emits 2 as the first prime, or tests odd candidates by trial division.
// Throughput: one request at a time; each trial waits on the bit-serial remainder unit.
// Reset (synchronous, active high) clears the sequencer, count, candidate (3) and
// limit (4096); the prime table needs no clearing pass.
module prime_generator_trial_division #(
  parameter int PRIME_STORE_DEPTH = pgtd_pkg::PRIME_STORE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [pgtd_pkg::COUNT_W-1:0]  cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          next_request,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pgtd_pkg::PRIME_W-1:0]  prime_value,
  output logic [pgtd_pkg::COUNT_W-1:0]  prime_ordinal,
  output logic                          store_full
);

  localparam int AW = $clog2(PRIME_STORE_DEPTH);
  localparam logic [pgtd_pkg::COUNT_W-1:0] DEPTH_C = pgtd_pkg::COUNT_W'(PRIME_STORE_DEPTH);

  pgtd_pkg::step_t   pc;
  pgtd_pkg::step_t   pc_next;
  pgtd_pkg::uword_t  uw;
  logic              jump;

  logic [pgtd_pkg::COUNT_W-1:0] max_primes;
  logic [pgtd_pkg::COUNT_W-1:0] found_count;
  logic [pgtd_pkg::COUNT_W-1:0] limit;
  logic [pgtd_pkg::CAND_W-1:0]  cand;
  logic [AW-1:0]                idx;
  logic [pgtd_pkg::PRIME_W-1:0] p;
  logic [2*pgtd_pkg::PRIME_W-1:0] sq;

  logic [pgtd_pkg::PRIME_W-1:0] tbl [PRIME_STORE_DEPTH];
  logic [pgtd_pkg::PRIME_W-1:0] rd_data;
  logic [pgtd_pkg::PRIME_W-1:0] wr_data;

  pgtd_pkg::rem_stat_t rem_stat;

  assign uw       = pgtd_pkg::ucode(pc);
  assign in_ready = (pc == pgtd_pkg::S_IDLE);
  assign limit    = (max_primes > DEPTH_C) ? DEPTH_C : max_primes;

  always_comb begin
    unique case (uw.cond)
      pgtd_pkg::C_NEVER:    jump = 1'b0;
      pgtd_pkg::C_ALWAYS:   jump = 1'b1;
      pgtd_pkg::C_NO_REQ:   jump = !(in_valid && next_request);
      pgtd_pkg::C_OUT_BUSY: jump = out_valid && !out_ready;
      pgtd_pkg::C_FULL:     jump = found_count >= limit;
      pgtd_pkg::C_FIRST:    jump = found_count == '0;
      pgtd_pkg::C_IDX_END:  jump = pgtd_pkg::COUNT_W'(idx) >= found_count;
      pgtd_pkg::C_SQ_GT:    jump = sq > (2*pgtd_pkg::PRIME_W)'(cand);
      pgtd_pkg::C_DIV_BUSY: jump = rem_stat.busy;
      pgtd_pkg::C_REM_NZ:   jump = !rem_stat.zero;
      default:              jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + pgtd_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= pgtd_pkg::S_IDLE;
      max_primes  <= pgtd_pkg::MAX_PRIMES_RST;
      found_count <= '0;
      cand        <= pgtd_pkg::CAND_RST;
      out_valid   <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_write_en) begin
        max_primes <= cfg_write_data;
      end
      if (uw.cnt_inc) begin
        found_count <= found_count + pgtd_pkg::COUNT_W'(1);
      end
      if (uw.cand_inc) begin
        cand <= cand + pgtd_pkg::CAND_STEP;
      end
      if (uw.emit != pgtd_pkg::EM_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uw.idx_clr) begin
      idx <= '0;
    end else if (uw.idx_inc) begin
      idx <= idx + AW'(1);
    end
    if (uw.p_ld) begin
      p <= rd_data;
    end
    if (uw.sq_ld) begin
      sq <= (2*pgtd_pkg::PRIME_W)'(p) * (2*pgtd_pkg::PRIME_W)'(p);
    end
  end

  assign wr_data = (uw.emit == pgtd_pkg::EM_TWO) ? pgtd_pkg::FIRST_PRIME
                                                 : cand[pgtd_pkg::PRIME_W-1:0];

  always_ff @(posedge clk) begin
    if (uw.tbl_wr) begin
      tbl[found_count[AW-1:0]] <= wr_data;
    end
    rd_data <= tbl[idx];
  end

  always_ff @(posedge clk) begin
    case (uw.emit)
      pgtd_pkg::EM_PRIME, pgtd_pkg::EM_TWO: begin
        prime_value   <= wr_data;
        prime_ordinal <= found_count;
        store_full    <= 1'b0;
      end
      pgtd_pkg::EM_FULL: begin
        prime_value   <= '0;
        prime_ordinal <= found_count;
        store_full    <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  pgtd_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (uw.div_go),
    .dividend (cand),
    .divisor  (p),
    .stat     (rem_stat)
  );

endmodule

>>> src/pgtd_check.sv
module pgtd_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pgtd_pkg::PRIME_W-1:0]  prime_value,
  input logic [pgtd_pkg::COUNT_W-1:0]  prime_ordinal,
  input logic                          store_full
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("request result valid or input blocked after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prime_value) && $stable(prime_ordinal))
    else $error("stalled result changed");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_full |-> prime_value == '0)
    else $error("full result carries a prime");

  a_first_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && !store_full && prime_ordinal == '0 |-> prime_value == pgtd_pkg::FIRST_PRIME)
    else $error("first prime is not 2");

  a_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid && !store_full && prime_ordinal != '0 |-> prime_value[0])
    else $error("later prime is even");

endmodule

bind prime_generator_trial_division pgtd_check u_check (.*);

>>> dv/prime_generator_trial_division_tb.sv
module prime_generator_trial_division_tb;

  localparam int REQUEST_TARGET = 1200;
  localparam int PRIME_BUDGET = 500;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [pgtd_pkg::PRIME_W-1:0] value;
    logic [pgtd_pkg::COUNT_W-1:0] ordinal;
    logic                         full;
  } prime_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic                         req;
    logic [pgtd_pkg::COUNT_W-1:0] limit;
    logic                         typed;
    prime_result_t                want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [pgtd_pkg::COUNT_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic next_request = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [pgtd_pkg::PRIME_W-1:0] prime_value;
  logic [pgtd_pkg::COUNT_W-1:0] prime_ordinal;
  logic store_full;

  prime_result_t primes_due [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit long_hold_go = 1'b0;

  // predictor state
  logic [pgtd_pkg::PRIME_W-1:0] known_primes [pgtd_pkg::PRIME_STORE_DEPTH];
  int unsigned prime_count = 0;
  int unsigned odd_cand = 3;
  int unsigned limit_setting = 4096;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_REQ, 1'b0, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b1, '{16'd2, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b0, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_CFG, 1'b0, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b1, '{16'd0, 13'd3, 1'b1}},
    '{ROW_REQ, 1'b0, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b1, '{16'd0, 13'd3, 1'b1}},
    '{ROW_CFG, 1'b0, 13'd1,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b1, '{16'd0, 13'd3, 1'b1}},
    '{ROW_CFG, 1'b0, 13'h1FFF, 1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_CFG, 1'b0, 13'd5,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b1, '{16'd0, 13'd5, 1'b1}},
    '{ROW_CFG, 1'b0, 13'd6,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b1, '{16'd0, 13'd6, 1'b1}},
    '{ROW_CFG, 1'b0, 13'd4096, 1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_CFG, 1'b0, 13'hFFF,  1'b0, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ, 1'b1, 13'd0,    1'b0, '{16'd0, 13'd0, 1'b0}}
  };

  prime_generator_trial_division DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .next_request   (next_request),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .prime_value    (prime_value),
    .prime_ordinal  (prime_ordinal),
    .store_full     (store_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // next prime by trial division over the primes found so far
  task automatic compute_next_prime(output prime_result_t r);
    int unsigned cap;
    int unsigned i;
    int unsigned p;
    bit composite;
    cap = (limit_setting > pgtd_pkg::PRIME_STORE_DEPTH) ? pgtd_pkg::PRIME_STORE_DEPTH
                                                         : limit_setting;
    r = '0;
    if (prime_count >= cap) begin
      r.ordinal = prime_count[pgtd_pkg::COUNT_W-1:0];
      r.full = 1'b1;
    end else begin
      if (prime_count == 0) begin
        r.value = pgtd_pkg::FIRST_PRIME;
        known_primes[0] = pgtd_pkg::FIRST_PRIME;
      end else begin
        do begin
          composite = 1'b0;
          for (i = 0; i < prime_count && i < pgtd_pkg::PRIME_STORE_DEPTH; i++) begin
            p = 32'(known_primes[i]);
            if (p * p > odd_cand) break;
            if (odd_cand % p == 0) begin
              composite = 1'b1;
              break;
            end
          end
          if (composite) odd_cand = (odd_cand + 32'(pgtd_pkg::CAND_STEP)) & 32'h1FFFF;
        end while (composite);
        r.value = odd_cand[pgtd_pkg::PRIME_W-1:0];
        known_primes[prime_count[11:0]] = odd_cand[pgtd_pkg::PRIME_W-1:0];
        odd_cand = (odd_cand + 32'(pgtd_pkg::CAND_STEP)) & 32'h1FFFF;
      end
      r.ordinal = prime_count[pgtd_pkg::COUNT_W-1:0];
      prime_count = (prime_count + 1) & 32'h1FFF;
    end
  endtask

  task automatic offer_request(input logic req, input logic typed, input prime_result_t want);
    prime_result_t r;
    in_valid <= 1'b1;
    next_request <= req;
    do @(posedge clk); while (!in_ready);
    if (req) begin
      compute_next_prime(r);
      primes_due.push_back(typed ? want : r);
    end
  endtask

  task automatic write_limit(input logic [pgtd_pkg::COUNT_W-1:0] lim);
    in_valid <= 1'b0;
    @(posedge clk);
    while (primes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= lim;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    limit_setting = 32'(lim);
  endtask

  task automatic note_mismatch(input string what, input prime_result_t want,
                               input prime_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0s: exp value=%0d ordinal=%0d full=%0b, got value=%0d ordinal=%0d full=%0b",
               what, want.value, want.ordinal, want.full, got.value, got.ordinal, got.full);
  endtask

  always @(posedge clk) begin
    prime_result_t got;
    prime_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{prime_value, prime_ordinal, store_full};
      if (primes_due.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = primes_due.pop_front();
        if (got.value !== want.value || got.ordinal !== want.ordinal ||
            got.full !== want.full)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // receiver: stall pattern is redrawn at random intervals, plus one long hold-off
  initial begin
    int pattern_left;
    int stall_pct;
    bit long_hold_done;
    pattern_left = 0;
    stall_pct = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_go && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 128);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pattern_left--;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    int gap;
    int burst;
    int left;
    int phase;
    int requests_sent;
    logic req;
    bit drain;
    logic [pgtd_pkg::COUNT_W-1:0] lim;
    known_primes[0] = pgtd_pkg::FIRST_PRIME;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_limit(directed_rows[i].limit);
      end else begin
        offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    phase = 0;
    requests_sent = 0;
    while (requests_sent < REQUEST_TARGET) begin
      case ($urandom_range(0, 7))
        0: lim = '0;
        1: lim = pgtd_pkg::COUNT_W'($urandom_range(1, prime_count));
        default: begin
          if (prime_count + 40 < PRIME_BUDGET)
            lim = pgtd_pkg::COUNT_W'(prime_count + $urandom_range(1, 40));
          else
            lim = pgtd_pkg::COUNT_W'($urandom_range(0, prime_count));
        end
      endcase
      write_limit(lim);
      if (phase == 3) long_hold_go = 1'b1;
      left = $urandom_range(20, 80);
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        if (burst > left) burst = left;
        repeat (burst) begin
          req = ($urandom_range(0, 3) != 0);
          offer_request(req, 1'b0, '0);
          requests_sent++;
        end
        left -= burst;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        drain = ($urandom_range(0, 19) == 0);
        if (drain && gap == 0) gap = 1;
        if (gap > 0 || drain) begin
          in_valid <= 1'b0;
          next_request <= 1'($urandom_range(0, 1));
          if (drain) while (primes_due.size() != 0) @(posedge clk);
          repeat (gap) @(posedge clk);
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (primes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
src/pgtd_pkg.sv
src/pgtd_rem.sv
src/prime_generator_trial_division.sv
src/pgtd_check.sv
dv/prime_generator_trial_division_tb.sv
